/* rtl/tdma_slot_receive_checker_assert.svh */
// Assertion macros for the checker file.
`ifndef TDMA_SLOT_RECEIVE_CHECKER_ASSERT_SVH
`define TDMA_SLOT_RECEIVE_CHECKER_ASSERT_SVH

// Checked on every rising edge while reset is released.
`define TSRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TSRC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/tsrc_pkg.sv */
`default_nettype none
package tsrc_pkg;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [15:0] HDR_BYTES    = 16'd20;
	localparam logic [63:0] LATENCY_STEP = 64'd10;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_MASTER     = 3'd1;
	localparam logic [2:0] ST_SENDER     = 3'd2;
	localparam logic [2:0] ST_UNSYNCED   = 3'd3;
	localparam logic [2:0] ST_MALFORMED  = 3'd4;
	localparam logic [2:0] ST_MISMATCH   = 3'd5;
	localparam logic [2:0] ST_WINDOW     = 3'd6;
	localparam logic [2:0] ST_ZERO_CYCLE = 3'd7;

	localparam logic CFG_OWN_SLOT    = 1'b0;
	localparam logic CFG_SENDER_MODE = 1'b1;

	typedef enum logic [2:0] {
		K_QUERY,
		K_MALFORMED,
		K_MISMATCH,
		K_MASTER,
		K_SENDER,
		K_DATA
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [63:0] local_time_us;
		logic [15:0] datagram_length;
		logic [63:0] header_sequence;
		logic [63:0] sender_clock_us;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        packet_loss;
		logic [31:0] latency_us;
		logic [15:0] payload_length;
		logic [63:0] slot_wait_us;
	} res_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_MSYNC,
		B_TIME,
		B_MADJ,
		B_MUL_CYC,
		B_MUL_OFS,
		B_DIV,
		B_START,
		B_CALC,
		B_FIN,
		B_DONE
	} bstate_t;

	function automatic logic [31:0] swap32(input logic [31:0] v);
		return {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage
`default_nettype wire

/* rtl/tsrc_front.sv */
`default_nettype none
module tsrc_front (
	input  wire logic          cmd,
	input  wire logic [63:0]   local_time_us,
	input  wire logic [15:0]   datagram_length,
	input  wire logic [31:0]   header_slot,
	input  wire logic [63:0]   header_sequence,
	input  wire logic [63:0]   sender_clock_us,
	input  wire logic [31:0]   own_slot,
	input  wire logic          sender_mode,
	output tsrc_pkg::item_t    item
);

	tsrc_pkg::kind_t kind;

	always_comb begin
		priority if (cmd) begin
			kind = tsrc_pkg::K_QUERY;
		end else if (datagram_length < tsrc_pkg::HDR_BYTES) begin
			kind = tsrc_pkg::K_MALFORMED;
		end else if (header_slot != own_slot && header_slot != 32'd0) begin
			kind = tsrc_pkg::K_MISMATCH;
		end else if (header_slot == 32'd0) begin
			kind = tsrc_pkg::K_MASTER;
		end else if (sender_mode) begin
			kind = tsrc_pkg::K_SENDER;
		end else begin
			kind = tsrc_pkg::K_DATA;
		end
	end

	assign item.kind            = kind;
	assign item.local_time_us   = local_time_us;
	assign item.datagram_length = datagram_length;
	assign item.header_sequence = header_sequence;
	assign item.sender_clock_us = sender_clock_us;

endmodule
`default_nettype wire

/* rtl/tsrc_queue.sv */
`default_nettype none
module tsrc_queue #(
	parameter int DEPTH = tsrc_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  tsrc_pkg::item_t      push_item,
	output logic                 full,
	input  wire logic            pop,
	output logic                 not_empty,
	output tsrc_pkg::item_t      head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tsrc_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	assign full      = (cnt_q == CW'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

/* rtl/tsrc_back.sv */
`default_nettype none
module tsrc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          not_empty,
	input  tsrc_pkg::item_t    head,
	output logic               pop,
	input  wire logic [31:0]   own_slot,
	output logic               out_valid,
	input  wire logic          out_stall,
	output tsrc_pkg::res_t     out_res
);

	tsrc_pkg::bstate_t state_q, state_d;
	tsrc_pkg::item_t   it_q;
	tsrc_pkg::res_t    res_q;
	tsrc_pkg::res_t    idle_res;

	logic [31:0] slot_total_q, slot_length_q;
	logic [63:0] offset_q, last_seq_q;
	logic [63:0] now_q, cyc_q, ofs_q, rem_q, dvd_q, start_q;
	logic [5:0]  cnt_q;
	logic        win_q, out_valid_q;

	logic [31:0] mul_a;
	logic [63:0] mul_p;
	logic [64:0] trial;
	logic        fits, deliver;

	assign mul_a   = (state_q == tsrc_pkg::B_MUL_CYC) ? slot_total_q : own_slot;
	assign mul_p   = 64'(slot_length_q) * 64'(mul_a);
	assign trial   = {rem_q, dvd_q[63]};
	assign fits    = trial >= {1'b0, cyc_q};
	assign deliver = (state_q == tsrc_pkg::B_DONE) && (!out_valid_q || !out_stall);
	assign pop     = (state_q == tsrc_pkg::B_IDLE) && not_empty;
	assign out_valid = out_valid_q;

	always_comb begin
		idle_res = '0;
		unique case (head.kind)
			tsrc_pkg::K_MALFORMED: idle_res.status = tsrc_pkg::ST_MALFORMED;
			tsrc_pkg::K_MISMATCH:  idle_res.status = tsrc_pkg::ST_MISMATCH;
			tsrc_pkg::K_SENDER:    idle_res.status = tsrc_pkg::ST_SENDER;
			default:               idle_res.status = tsrc_pkg::ST_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tsrc_pkg::B_IDLE: begin
				if (not_empty) begin
					unique case (head.kind)
						tsrc_pkg::K_MALFORMED, tsrc_pkg::K_MISMATCH,
						tsrc_pkg::K_SENDER: state_d = tsrc_pkg::B_DONE;
						tsrc_pkg::K_MASTER: state_d = tsrc_pkg::B_MSYNC;
						default: state_d = tsrc_pkg::B_TIME;
					endcase
				end
			end
			tsrc_pkg::B_MSYNC: state_d = tsrc_pkg::B_TIME;
			tsrc_pkg::B_TIME: begin
				state_d = (it_q.kind == tsrc_pkg::K_MASTER) ? tsrc_pkg::B_MADJ
				                                            : tsrc_pkg::B_MUL_CYC;
			end
			tsrc_pkg::B_MADJ: state_d = tsrc_pkg::B_DONE;
			tsrc_pkg::B_MUL_CYC: begin
				// A data header with no sync is rejected before the cycle length matters.
				if (it_q.kind == tsrc_pkg::K_DATA && now_q == 64'd0) begin
					state_d = tsrc_pkg::B_DONE;
				end else begin
					state_d = tsrc_pkg::B_MUL_OFS;
				end
			end
			tsrc_pkg::B_MUL_OFS: begin
				state_d = (cyc_q == 64'd0) ? tsrc_pkg::B_DONE : tsrc_pkg::B_DIV;
			end
			tsrc_pkg::B_DIV: begin
				if (cnt_q == 6'd63) begin
					state_d = tsrc_pkg::B_START;
				end
			end
			tsrc_pkg::B_START: state_d = tsrc_pkg::B_CALC;
			tsrc_pkg::B_CALC:  state_d = tsrc_pkg::B_FIN;
			tsrc_pkg::B_FIN:   state_d = tsrc_pkg::B_DONE;
			tsrc_pkg::B_DONE: begin
				if (deliver) begin
					state_d = tsrc_pkg::B_IDLE;
				end
			end
			default: state_d = tsrc_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tsrc_pkg::B_IDLE;
			out_valid_q   <= 1'b0;
			slot_total_q  <= '0;
			slot_length_q <= '0;
			offset_q      <= '0;
			last_seq_q    <= '0;
		end else begin
			state_q <= state_d;
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == tsrc_pkg::B_MSYNC) begin
				slot_total_q  <= tsrc_pkg::swap32(it_q.header_sequence[63:32]);
				slot_length_q <= tsrc_pkg::swap32(it_q.header_sequence[31:0]);
				if (offset_q == 64'd0) begin
					offset_q <= it_q.local_time_us - it_q.sender_clock_us;
				end
			end
			// Latency improved: the offset creeps up by a fixed step.
			if (state_q == tsrc_pkg::B_MADJ && it_q.sender_clock_us < now_q) begin
				offset_q <= offset_q + tsrc_pkg::LATENCY_STEP;
			end
			if (state_q == tsrc_pkg::B_FIN && it_q.kind == tsrc_pkg::K_DATA && win_q) begin
				last_seq_q <= it_q.header_sequence;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tsrc_pkg::B_IDLE: begin
				it_q  <= head;
				res_q <= idle_res;
			end
			tsrc_pkg::B_TIME: begin
				now_q <= (offset_q == 64'd0) ? 64'd0 : it_q.local_time_us - offset_q;
			end
			tsrc_pkg::B_MADJ: begin
				res_q.status         <= tsrc_pkg::ST_MASTER;
				res_q.payload_length <= it_q.datagram_length - tsrc_pkg::HDR_BYTES;
			end
			tsrc_pkg::B_MUL_CYC: begin
				cyc_q <= mul_p;
				if (it_q.kind == tsrc_pkg::K_DATA && now_q == 64'd0) begin
					res_q.status <= tsrc_pkg::ST_UNSYNCED;
				end
			end
			tsrc_pkg::B_MUL_OFS: begin
				ofs_q <= mul_p;
				rem_q <= '0;
				dvd_q <= now_q;
				cnt_q <= '0;
				if (cyc_q == 64'd0) begin
					res_q.status <= tsrc_pkg::ST_ZERO_CYCLE;
				end
			end
			tsrc_pkg::B_DIV: begin
				// One remainder bit per cycle, most significant dividend bit first.
				rem_q <= fits ? 64'(trial - {1'b0, cyc_q}) : trial[63:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			tsrc_pkg::B_START: begin
				start_q <= now_q - rem_q + ofs_q;
			end
			tsrc_pkg::B_CALC: begin
				if (it_q.kind == tsrc_pkg::K_QUERY && start_q < now_q) begin
					start_q <= start_q + cyc_q;
				end
				win_q <= (start_q < now_q) && (start_q + 64'(slot_length_q) > now_q);
			end
			tsrc_pkg::B_FIN: begin
				if (it_q.kind == tsrc_pkg::K_QUERY) begin
					res_q.slot_wait_us <= start_q - now_q;
				end else if (!win_q) begin
					res_q.status <= tsrc_pkg::ST_WINDOW;
				end else begin
					res_q.packet_loss    <= (last_seq_q != 64'd0) &&
					                        (it_q.header_sequence != last_seq_q + 64'd1);
					res_q.latency_us     <= 32'(now_q - it_q.sender_clock_us);
					res_q.payload_length <= it_q.datagram_length - tsrc_pkg::HDR_BYTES;
				end
			end
			default: begin
			end
		endcase
		if (deliver) begin
			out_res <= res_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/tdma_slot_receive_checker.sv */
`default_nettype none
// TDMA slot receive checker: each transfer on the input channel yields exactly one result
// transfer, in order. Rejected headers (malformed, foreign slot, sender mode) go straight
// to the result; an unsynced data header, a master sync header and a zero cycle length end
// without the remainder unit, and window checks and wait queries pass through the remainder
// unit, which produces one bit of the 64-bit synced time modulo the cycle length per cycle.
// The next item starts the cycle after a result moves to the output register.
// A small input queue takes further items while one is worked on;
// configuration writes are always ready and must only happen while the block is idle.
module tdma_slot_receive_checker #(
	parameter int QUEUE_DEPTH = tsrc_pkg::QUEUE_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          cmd,
	input  wire logic [63:0]   local_time_us,
	input  wire logic [15:0]   datagram_length,
	input  wire logic [31:0]   header_slot,
	input  wire logic [63:0]   header_sequence,
	input  wire logic [63:0]   sender_clock_us,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [2:0]         status,
	output logic               packet_loss,
	output logic [31:0]        latency_us,
	output logic [15:0]        payload_length,
	output logic [63:0]        slot_wait_us,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic          cfg_index,
	input  wire logic [31:0]   cfg_data
);

	logic [31:0] own_slot_q;
	logic        sender_mode_q;
	logic        full, not_empty, pop;
	tsrc_pkg::item_t front_item, head;
	tsrc_pkg::res_t  res;

	assign cfg_ready = 1'b1;
	assign in_stall  = full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_slot_q    <= 32'd1;
			sender_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsrc_pkg::CFG_OWN_SLOT:    own_slot_q    <= cfg_data;
				tsrc_pkg::CFG_SENDER_MODE: sender_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tsrc_front u_front (
		.cmd             (cmd),
		.local_time_us   (local_time_us),
		.datagram_length (datagram_length),
		.header_slot     (header_slot),
		.header_sequence (header_sequence),
		.sender_clock_us (sender_clock_us),
		.own_slot        (own_slot_q),
		.sender_mode     (sender_mode_q),
		.item            (front_item)
	);

	tsrc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_valid && !in_stall),
		.push_item (front_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	tsrc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.own_slot  (own_slot_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (res)
	);

	assign status         = res.status;
	assign packet_loss    = res.packet_loss;
	assign latency_us     = res.latency_us;
	assign payload_length = res.payload_length;
	assign slot_wait_us   = res.slot_wait_us;

endmodule
`default_nettype wire

/* rtl/tsrc_checker.sv */
`default_nettype none
`include "tdma_slot_receive_checker_assert.svh"
module tsrc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic        packet_loss,
	input wire logic [31:0] latency_us,
	input wire logic [15:0] payload_length,
	input wire logic [63:0] slot_wait_us
);

	// A result waiting on a stalled receiver stays put.
	`TSRC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_wait_us), "stalled result changed")

	// Loss, latency and wait are only reported on an accepted packet or query.
	`TSRC_ASSERT(a_ok_fields, out_valid && (packet_loss || latency_us != 32'd0 || slot_wait_us != 64'd0) |-> status == tsrc_pkg::ST_OK, "ok-only field on rejected item")

	// Payload length comes only with an accepted packet or a master sync.
	`TSRC_ASSERT(a_payload, out_valid && payload_length != 16'd0 |-> status == tsrc_pkg::ST_OK || status == tsrc_pkg::ST_MASTER, "payload on rejected item")

	// No result can leave in the cycle right after reset.
	`TSRC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !out_valid, "result right after reset")

endmodule

bind tdma_slot_receive_checker tsrc_checker u_tsrc_checker (.*);
`default_nettype wire
